// ----- rtl/mch_pkg.sv -----
// Package for the monotone chain convex hull unit.
// Sizes, the queued point type and the store address widths; no dependencies.
package mch_pkg;
    localparam int MAX_POINTS  = 32;
    localparam int COORD_BITS  = 16;
    localparam int STACK_DEPTH = MAX_POINTS + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int SIDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int KW          = $clog2(STACK_DEPTH + 2);
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int PT_W        = 2 * COORD_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } point_t;
endpackage

// ----- rtl/mch_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
module mch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/mch_front.sv -----
// Front end: accepts point transactions into a short queue for the back end.
// Depends on mch_pkg.
module mch_front import mch_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic                  last_point,
    output logic                  q_valid,
    output point_t                q_item,
    input  logic                  q_pop
);
    point_t             buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_stall = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = buf_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= '{x: px, y: py, last: last_point};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

// ----- rtl/mch_back.sv -----
// Back end: insertion sort into the point store, monotone chain hull build
// and vertex output register. Depends on mch_pkg and mch_ram.
module mch_back import mch_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  point_t                q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] hull_x,
    output logic [COORD_BITS-1:0] hull_y,
    output logic                  last_vertex,
    output logic                  points_dropped
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRD   = 4'd1;
    localparam logic [3:0] ST_SCMP  = 4'd2;
    localparam logic [3:0] ST_SINS  = 4'd3;
    localparam logic [3:0] ST_HRD   = 4'd4;
    localparam logic [3:0] ST_HLD   = 4'd5;
    localparam logic [3:0] ST_HMUL  = 4'd6;
    localparam logic [3:0] ST_HCHK  = 4'd7;
    localparam logic [3:0] ST_HRELD = 4'd8;
    localparam logic [3:0] ST_HPUSH = 4'd9;
    localparam logic [3:0] ST_ERD   = 4'd10;
    localparam logic [3:0] ST_EPUT  = 4'd11;

    localparam int DW = COORD_BITS + 1;
    localparam int MW = 2 * DW;

    logic [3:0]                   state_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             pos_reg;
    logic                         ovf_reg;
    point_t                       new_reg;
    logic [SIDX_W-1:0]            i_reg;
    logic [KW-1:0]                k_reg;
    logic [KW-1:0]                lim_reg;
    logic [KW-1:0]                j_reg;
    logic                         upper_reg;
    logic signed [COORD_BITS-1:0] t1x_reg, t1y_reg, t2x_reg, t2y_reg;
    logic signed [COORD_BITS-1:0] ptx_reg, pty_reg;
    logic signed [MW-1:0]         p1_reg, p2_reg;
    logic [COORD_BITS-1:0]        hx_reg, hy_reg;
    logic                         ov_reg, lv_reg, ovalid_reg;

    logic                         s_we;
    logic [SIDX_W-1:0]            s_waddr, s_raddr;
    logic [PT_W-1:0]              s_wdata, s_rdata;
    logic                         k_we;
    logic [STK_AW-1:0]            k_waddr, k_raddr;
    logic [PT_W-1:0]              k_wdata, k_rdata;
    logic signed [COORD_BITS-1:0] srx, sry, krx, kry;
    logic                         less;
    logic signed [DW-1:0]         ax, ay, bx, by;
    logic [CNT_W-1:0]             posm1;
    logic [KW-1:0]                kpush;
    logic                         can_load;

    assign srx = s_rdata[PT_W-1:COORD_BITS];
    assign sry = s_rdata[COORD_BITS-1:0];
    assign krx = k_rdata[PT_W-1:COORD_BITS];
    assign kry = k_rdata[COORD_BITS-1:0];
    assign less = (new_reg.x < srx) || ((new_reg.x == srx) && (new_reg.y < sry));
    assign posm1 = pos_reg - 1'b1;
    assign ax = DW'(t1x_reg) - DW'(t2x_reg);
    assign ay = DW'(t1y_reg) - DW'(t2y_reg);
    assign bx = DW'(ptx_reg) - DW'(t2x_reg);
    assign by = DW'(pty_reg) - DW'(t2y_reg);
    assign kpush = (k_reg < KW'(STACK_DEPTH)) ? k_reg + 1'b1 : k_reg;
    assign can_load = !ovalid_reg || !out_stall;
    assign q_pop = (state_reg == ST_IDLE);

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = pos_reg[SIDX_W-1:0];
        s_wdata = {new_reg.x, new_reg.y};
        s_raddr = posm1[SIDX_W-1:0];
        if (state_reg == ST_SCMP && less)
        begin
            s_we    = 1'b1;
            s_wdata = s_rdata;
        end
        if (state_reg == ST_SINS)
        begin
            s_we = 1'b1;
        end
        if (state_reg == ST_HRD)
        begin
            s_raddr = i_reg;
        end
    end

    always_comb
    begin
        k_we    = (state_reg == ST_HPUSH) && (k_reg < KW'(STACK_DEPTH));
        k_waddr = k_reg[STK_AW-1:0];
        k_wdata = {ptx_reg, pty_reg};
        k_raddr = j_reg[STK_AW-1:0];
        if (state_reg == ST_HCHK)
        begin
            k_raddr = STK_AW'(k_reg - KW'(3));
        end
    end

    mch_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_sorted (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    mch_ram #(.WIDTH(PT_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            new_reg <= q_item;
        end
        if (state_reg == ST_HLD)
        begin
            ptx_reg <= srx;
            pty_reg <= sry;
        end
        if (state_reg == ST_HMUL)
        begin
            p1_reg <= ax * by;
            p2_reg <= ay * bx;
        end
        if (state_reg == ST_HRELD)
        begin
            t2x_reg <= krx;
            t2y_reg <= kry;
        end
        if (state_reg == ST_HCHK && p1_reg <= p2_reg)
        begin
            t1x_reg <= t2x_reg;
            t1y_reg <= t2y_reg;
        end
        if (k_we)
        begin
            t2x_reg <= t1x_reg;
            t2y_reg <= t1y_reg;
            t1x_reg <= ptx_reg;
            t1y_reg <= pty_reg;
        end
        if (state_reg == ST_EPUT && can_load)
        begin
            hx_reg <= krx;
            hy_reg <= kry;
            lv_reg <= (j_reg + 1'b1 == k_reg);
            ov_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            k_reg      <= '0;
            lim_reg    <= '0;
            j_reg      <= '0;
            upper_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        pos_reg <= count_reg;
                        if (count_reg >= CNT_W'(MAX_POINTS))
                        begin
                            ovf_reg <= 1'b1;
                            if (q_item.last)
                            begin
                                i_reg     <= '0;
                                k_reg     <= '0;
                                lim_reg   <= KW'(2);
                                upper_reg <= 1'b0;
                                state_reg <= ST_HRD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            state_reg <= ST_SINS;
                        end
                        else
                        begin
                            state_reg <= ST_SRD;
                        end
                    end
                end
                ST_SRD:
                begin
                    state_reg <= ST_SCMP;
                end
                ST_SCMP:
                begin
                    if (less)
                    begin
                        pos_reg   <= posm1;
                        state_reg <= (posm1 == '0) ? ST_SINS : ST_SRD;
                    end
                    else
                    begin
                        state_reg <= ST_SINS;
                    end
                end
                ST_SINS:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (new_reg.last)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        lim_reg   <= KW'(2);
                        upper_reg <= 1'b0;
                        state_reg <= ST_HRD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_HRD:
                begin
                    state_reg <= ST_HLD;
                end
                ST_HLD:
                begin
                    state_reg <= (k_reg >= lim_reg) ? ST_HMUL : ST_HPUSH;
                end
                ST_HMUL:
                begin
                    state_reg <= ST_HCHK;
                end
                ST_HCHK:
                begin
                    if (p1_reg <= p2_reg)
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= (k_reg - 1'b1 >= lim_reg) ? ST_HRELD : ST_HPUSH;
                    end
                    else
                    begin
                        state_reg <= ST_HPUSH;
                    end
                end
                ST_HRELD:
                begin
                    state_reg <= ST_HMUL;
                end
                ST_HPUSH:
                begin
                    k_reg <= kpush;
                    if (!upper_reg)
                    begin
                        if (KW'(i_reg) + 1'b1 == KW'(count_reg))
                        begin
                            upper_reg <= 1'b1;
                            lim_reg   <= kpush + 1'b1;
                            if (i_reg == '0)
                            begin
                                j_reg     <= '0;
                                state_reg <= ST_ERD;
                            end
                            else
                            begin
                                i_reg     <= i_reg - 1'b1;
                                state_reg <= ST_HRD;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_HRD;
                        end
                    end
                    else if (i_reg == '0)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_ERD;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_HRD;
                    end
                end
                ST_ERD:
                begin
                    state_reg <= ST_EPUT;
                end
                ST_EPUT:
                begin
                    if (can_load)
                    begin
                        ovalid_reg <= 1'b1;
                        if (j_reg + 1'b1 == k_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = ovalid_reg;
    assign hull_x         = hx_reg;
    assign hull_y         = hy_reg;
    assign last_vertex    = lv_reg;
    assign points_dropped = ov_reg;
endmodule

// ----- rtl/monotone_chain_convex_hull_unit.sv -----
// Top level of the monotone chain convex hull unit.
// Depends on mch_pkg, mch_front and mch_back.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | px, py, last_point
//  out     | out_valid/out_stall | hull_x, hull_y, last_vertex, points_dropped
//
// A point transaction is queued in a 4-entry queue; the store insertion reads the store
// from its end and shifts each larger point up one place through its single read port.
// The hull build reads each visited point, makes a turn test with the cross product and
// reloads the stack top per pop; each vertex is read from the stack into the output register.
// Reset clears counts and control; the stores need no clearing.
// A stalled output holds the back end; input transactions still queue.
module monotone_chain_convex_hull_unit import mch_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic                  last_point,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] hull_x,
    output logic [COORD_BITS-1:0] hull_y,
    output logic                  last_vertex,
    output logic                  points_dropped
);
    logic   q_valid;
    logic   q_pop;
    point_t q_item;

    mch_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .px         (px),
        .py         (py),
        .last_point (last_point),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    mch_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hull_x         (hull_x),
        .hull_y         (hull_y),
        .last_vertex    (last_vertex),
        .points_dropped (points_dropped)
    );
endmodule

// ----- tb/monotone_chain_convex_hull_unit_test.sv -----
// Testbench for the monotone chain convex hull unit: drives point sets, checks each vertex.
// Holds its own hull predictor in a scoreboard class; depends on mch_pkg and the RTL top level.
`timescale 1ns / 1ps

module monotone_chain_convex_hull_unit_test;
    import mch_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last_v;
        logic   dropped;
    } vertex_t;

    class hull_scoreboard;
        coord_t    set_x[$];
        coord_t    set_y[$];
        bit        overflow;
        vertex_t   pending[$];
        int        mismatches;

        function new();
            mismatches = 0;
            overflow = 0;
        endfunction

        function bit lower(coord_t ax, coord_t ay, coord_t bx, coord_t by);
            return (ax < bx) || (ax == bx && ay < by);
        endfunction

        function bit no_left(coord_t ox, coord_t oy, coord_t ax, coord_t ay,
                             coord_t bx, coord_t by);
            longint dax, day, dbx, dby;
            dax = longint'(ax) - ox;
            day = longint'(ay) - oy;
            dbx = longint'(bx) - ox;
            dby = longint'(by) - oy;
            return dax * dby <= day * dbx;
        endfunction

        function void note_point(coord_t x, coord_t y, logic last_p);
            int pos;
            int n;
            int k;
            int t;
            coord_t hx[$];
            coord_t hy[$];
            vertex_t v;
            if (set_x.size() >= MAX_POINTS)
                overflow = 1;
            else
            begin
                pos = set_x.size();
                while (pos > 0 && lower(x, y, set_x[pos-1], set_y[pos-1]))
                    pos--;
                set_x.insert(pos, x);
                set_y.insert(pos, y);
            end
            if (!last_p)
                return;
            n = set_x.size();
            for (int i = 0; i < n; i++)
            begin
                while (hx.size() >= 2 && no_left(hx[hx.size()-2], hy[hy.size()-2],
                       hx[hx.size()-1], hy[hy.size()-1], set_x[i], set_y[i]))
                begin
                    void'(hx.pop_back());
                    void'(hy.pop_back());
                end
                hx.insert(hx.size(), set_x[i]);
                hy.insert(hy.size(), set_y[i]);
            end
            t = hx.size() + 1;
            for (int i = n - 2; i >= 0; i--)
            begin
                while (hx.size() >= t && no_left(hx[hx.size()-2], hy[hy.size()-2],
                       hx[hx.size()-1], hy[hy.size()-1], set_x[i], set_y[i]))
                begin
                    void'(hx.pop_back());
                    void'(hy.pop_back());
                end
                if (hx.size() < STACK_DEPTH)
                begin
                    hx.insert(hx.size(), set_x[i]);
                    hy.insert(hy.size(), set_y[i]);
                end
            end
            k = hx.size();
            for (int j = 0; j < k; j++)
            begin
                v.x = hx[j];
                v.y = hy[j];
                v.last_v = (j + 1 == k);
                v.dropped = overflow;
                pending.insert(pending.size(), v);
            end
            set_x.delete();
            set_y.delete();
            overflow = 0;
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d", got.x, got.y);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"vertex mismatch: exp x=%0d y=%0d lv=%0b pd=%0b",
                              " got x=%0d y=%0d lv=%0b pd=%0b"},
                             want.x, want.y, want.last_v, want.dropped,
                             got.x, got.y, got.last_v, got.dropped);
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic            last_point;
    logic            out_valid;
    logic            out_stall;
    logic [COORD_BITS-1:0] hull_x;
    logic [COORD_BITS-1:0] hull_y;
    logic            last_vertex;
    logic            points_dropped;

    hull_scoreboard sb;
    int  idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    monotone_chain_convex_hull_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .px(px), .py(py), .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .hull_x(hull_x), .hull_y(hull_y),
        .last_vertex(last_vertex), .points_dropped(points_dropped)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // output side: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_vertex({coord_t'(hull_x), coord_t'(hull_y), last_vertex, points_dropped});
        out_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out)
        begin
            timed_out = 1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_point(coord_t x, coord_t y, logic last_p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        last_point <= last_p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_point(x, y, last_p);
    endtask

    task automatic send_set(int n, int span);
        coord_t x;
        coord_t y;
        for (int i = 0; i < n; i++)
        begin
            if (span == 0)
            begin
                x = coord_t'($urandom);
                y = coord_t'($urandom);
            end
            else
            begin
                x = coord_t'($urandom_range(2 * span) - span);
                y = coord_t'($urandom_range(2 * span) - span);
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    initial
    begin
        sb = new();
        idle_pct = 10;
        hold_off = 0;
        quiet_cycles = 0;
        timed_out = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        px = '0;
        py = '0;
        last_point = 1'b0;
        out_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single, pairs, duplicates, collinear, extremes, square
        send_point(16'sh0100, -16'sh0100, 1'b1);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b1);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd2, 16'sd2, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(16'sd3, 16'sd3, 1'b1);
        send_point(-16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(16'sh5555, 16'shaaaa, 1'b0);
        send_point(16'shaaaa, 16'sh5555, 1'b0);
        send_point(16'sd0, 16'sh5555, 1'b1);

        // overflow: more points than the store holds
        send_set(MAX_POINTS + 3, 0);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_set(12, 0);
                send_set(6, 0);
            end
        join

        // stretch with no idling
        idle_pct = 0;
        repeat (3) send_set($urandom_range(3, 8), 0);
        idle_pct = 10;

        for (int s = 0; s < 16; s++)
        begin
            if (s % 5 == 0)
                send_set($urandom_range(1, 2), 0);
            else
                send_set($urandom_range(3, 10), (s % 2) ? 8 : 0);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
